// ===== rtl/core/duration_dhms_alu_defines.svh =====
`ifndef DURATION_DHMS_ALU_DEFINES_SVH
`define DURATION_DHMS_ALU_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define DDA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define DDA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/dda_pkg.sv =====
`timescale 1ns / 1ps

package dda_pkg;

	// Default width of the days field.
	localparam int DAYS_BITS_DEFAULT = 16;

	// Width of the days carry that comes out of the hours stage.
	localparam int DCARRY_W = 16;

	// Radix constants.
	localparam logic [31:0] SEC_PER_MIN  = 32'd60;
	localparam logic [31:0] HOUR_PER_DAY = 32'd24;

	// Reciprocals: x / 60 = (x * RECIP_60) >> 37 and x / 3 = (x * RECIP_3) >> 33
	// for every 32-bit x.
	localparam logic [31:0] RECIP_60 = 32'h8888_8889;
	localparam logic [31:0] RECIP_3  = 32'hAAAA_AAAB;

	// Operation codes.
	typedef enum logic [2:0] {
		FUNC_ADD  = 3'd0,
		FUNC_SUB  = 3'd1,
		FUNC_CMP  = 3'd2,
		FUNC_INC  = 3'd3,
		FUNC_DEC  = 3'd4,
		FUNC_NORM = 3'd5,
		FUNC_SECS = 3'd6
	} func_t;

	// Whether an item still needs the carry stages or is already final.
	typedef enum logic {
		KIND_FINAL = 1'b0,
		KIND_CARRY = 1'b1
	} kind_t;

	// Compare result flags.
	typedef struct packed {
		logic lt;
		logic eq;
		logic gt;
	} cmp_flags_t;

	// Pipeline advance and occupancy, from the control in the top level.
	typedef struct packed {
		logic adv_s1;
		logic adv_s2;
		logic adv_s3;
		logic adv_s4;
		logic adv_o;
		logic vld_s3;
		logic vld_s4;
	} pipe_ctl_t;

	// Quotient by 60 through a reciprocal multiply.
	function automatic logic [31:0] div60(input logic [31:0] x);
		logic [63:0] p;
		p = {32'd0, x} * {32'd0, RECIP_60};
		return {5'd0, p[63:37]};
	endfunction

	// Quotient by 24: a shift by three, then a reciprocal multiply by three.
	function automatic logic [31:0] div24(input logic [31:0] x);
		logic [63:0] p;
		p = {35'd0, x[31:3]} * {32'd0, RECIP_3};
		return {1'b0, p[63:33]};
	endfunction

endpackage

// ===== rtl/core/dda_req_if.sv =====
`timescale 1ns / 1ps

interface dda_req_if import dda_pkg::*; #(
	parameter int DAYS_BITS = DAYS_BITS_DEFAULT
) ();
	logic                 valid;
	logic                 ready;
	logic [2:0]           func;
	logic [DAYS_BITS-1:0] a_days;
	logic [7:0]           a_hours;
	logic [7:0]           a_minutes;
	logic [7:0]           a_seconds;
	logic [DAYS_BITS-1:0] b_days;
	logic [7:0]           b_hours;
	logic [7:0]           b_minutes;
	logic [7:0]           b_seconds;
	logic [31:0]          total_seconds;

	modport source (
		output valid, func, a_days, a_hours, a_minutes, a_seconds,
		output b_days, b_hours, b_minutes, b_seconds, total_seconds,
		input  ready
	);

	modport sink (
		input  valid, func, a_days, a_hours, a_minutes, a_seconds,
		input  b_days, b_hours, b_minutes, b_seconds, total_seconds,
		output ready
	);
endinterface

// ===== rtl/core/dda_rsp_if.sv =====
`timescale 1ns / 1ps

interface dda_rsp_if import dda_pkg::*; #(
	parameter int DAYS_BITS = DAYS_BITS_DEFAULT
) ();
	logic                 valid;
	logic                 ready;
	logic [DAYS_BITS-1:0] out_days;
	logic [7:0]           out_hours;
	logic [7:0]           out_minutes;
	logic [7:0]           out_seconds;
	logic                 is_less;
	logic                 is_equal;
	logic                 is_greater;

	modport source (
		output valid, out_days, out_hours, out_minutes, out_seconds,
		output is_less, is_equal, is_greater,
		input  ready
	);

	modport sink (
		input  valid, out_days, out_hours, out_minutes, out_seconds,
		input  is_less, is_equal, is_greater,
		output ready
	);
endinterface

// ===== rtl/core/dda_front.sv =====
`timescale 1ns / 1ps

module dda_front import dda_pkg::*; #(
	parameter int DAYS_BITS = DAYS_BITS_DEFAULT
) (
	input  logic                 clk,
	input  pipe_ctl_t            ctl,
	input  logic [2:0]           func,
	input  logic [DAYS_BITS-1:0] a_days,
	input  logic [7:0]           a_hours,
	input  logic [7:0]           a_minutes,
	input  logic [7:0]           a_seconds,
	input  logic [DAYS_BITS-1:0] b_days,
	input  logic [7:0]           b_hours,
	input  logic [7:0]           b_minutes,
	input  logic [7:0]           b_seconds,
	input  logic [31:0]          total_seconds,
	output kind_t                kind_s2,
	output logic [DAYS_BITS:0]   days_s2,
	output logic [8:0]           hours_s2,
	output logic [31:0]          minutes_s2,
	output logic [7:0]           seconds_s2,
	output cmp_flags_t           flags_s2
);

	logic [2:0]           func_s1;
	logic [DAYS_BITS-1:0] a_days_s1;
	logic [7:0]           a_hours_s1;
	logic [7:0]           a_minutes_s1;
	logic [7:0]           a_seconds_s1;
	logic [DAYS_BITS-1:0] b_days_s1;
	logic [7:0]           b_hours_s1;
	logic [7:0]           b_minutes_s1;
	logic [7:0]           b_seconds_s1;
	logic [31:0]          total_seconds_s1;

	func_t                func_e;

	logic [DAYS_BITS-1:0] sub_bd;
	logic [7:0]           sub_bh;
	logic [7:0]           sub_bm;
	logic [7:0]           sub_bs;
	logic [DAYS_BITS+1:0] dif_d;
	logic [9:0]           dif_h;
	logic [9:0]           dif_m;
	logic [9:0]           dif_s;
	logic                 bor_neg;

	kind_t                kind_d;
	cmp_flags_t           flags_d;
	logic [31:0]          sec_src;
	logic [8:0]           min_src;
	logic [8:0]           hr_src;
	logic [DAYS_BITS:0]   day_src;
	logic [DAYS_BITS:0]   fin_days;
	logic [8:0]           fin_hours;
	logic [31:0]          fin_minutes;
	logic [7:0]           fin_seconds;
	logic [31:0]          sec_q;
	logic [31:0]          sec_r;

	logic [DAYS_BITS:0]   days_d;
	logic [8:0]           hours_d;
	logic [31:0]          minutes_d;
	logic [7:0]           seconds_d;

	// Input register.
	always_ff @(posedge clk) begin
		if (ctl.adv_s1) begin
			func_s1          <= func;
			a_days_s1        <= a_days;
			a_hours_s1       <= a_hours;
			a_minutes_s1     <= a_minutes;
			a_seconds_s1     <= a_seconds;
			b_days_s1        <= b_days;
			b_hours_s1       <= b_hours;
			b_minutes_s1     <= b_minutes;
			b_seconds_s1     <= b_seconds;
			total_seconds_s1 <= total_seconds;
		end
	end

	assign func_e = func_t'(func_s1);

	// Field differences with one borrow per level; decrement subtracts one second.
	always_comb begin
		sub_bd = (func_e == FUNC_DEC) ? '0 : b_days_s1;
		sub_bh = (func_e == FUNC_DEC) ? '0 : b_hours_s1;
		sub_bm = (func_e == FUNC_DEC) ? '0 : b_minutes_s1;
		sub_bs = (func_e == FUNC_DEC) ? 8'd1 : b_seconds_s1;
		dif_d  = {2'b00, a_days_s1} - {2'b00, sub_bd};
		dif_h  = {2'b00, a_hours_s1} - {2'b00, sub_bh};
		dif_m  = {2'b00, a_minutes_s1} - {2'b00, sub_bm};
		dif_s  = {2'b00, a_seconds_s1} - {2'b00, sub_bs};
		if (dif_s[9]) begin
			dif_m = dif_m - 10'd1;
			dif_s = dif_s + 10'd60;
		end
		if (dif_m[9]) begin
			dif_h = dif_h - 10'd1;
			dif_m = dif_m + 10'd60;
		end
		if (dif_h[9]) begin
			dif_d = dif_d - {{(DAYS_BITS+1){1'b0}}, 1'b1};
			dif_h = dif_h + 10'd24;
		end
		bor_neg = dif_d[DAYS_BITS+1] | dif_h[9] | dif_m[9] | dif_s[9];
	end

	// Operand selection for the carry chain, and results that need no carry.
	always_comb begin
		kind_d      = KIND_FINAL;
		flags_d     = '0;
		sec_src     = '0;
		min_src     = '0;
		hr_src      = '0;
		day_src     = '0;
		fin_days    = '0;
		fin_hours   = '0;
		fin_minutes = '0;
		fin_seconds = '0;
		unique case (func_e)
			FUNC_ADD: begin
				kind_d  = KIND_CARRY;
				sec_src = 32'(a_seconds_s1) + 32'(b_seconds_s1);
				min_src = 9'(a_minutes_s1) + 9'(b_minutes_s1);
				hr_src  = 9'(a_hours_s1) + 9'(b_hours_s1);
				day_src = (DAYS_BITS+1)'(a_days_s1) + (DAYS_BITS+1)'(b_days_s1);
			end
			FUNC_SUB, FUNC_DEC: begin
				if (!bor_neg) begin
					fin_days    = {1'b0, dif_d[DAYS_BITS-1:0]};
					fin_hours   = {1'b0, dif_h[7:0]};
					fin_minutes = 32'(dif_m[7:0]);
					fin_seconds = dif_s[7:0];
				end
			end
			FUNC_CMP: begin
				flags_d.eq = (a_days_s1 == b_days_s1) && (a_hours_s1 == b_hours_s1) &&
					(a_minutes_s1 == b_minutes_s1) && (a_seconds_s1 == b_seconds_s1);
				flags_d.lt = (a_days_s1 < b_days_s1) ||
					((a_days_s1 == b_days_s1) && ((a_hours_s1 < b_hours_s1) ||
					((a_hours_s1 == b_hours_s1) && ((a_minutes_s1 < b_minutes_s1) ||
					((a_minutes_s1 == b_minutes_s1) && (a_seconds_s1 < b_seconds_s1))))));
				flags_d.gt = !flags_d.lt && !flags_d.eq;
			end
			FUNC_INC: begin
				kind_d  = KIND_CARRY;
				sec_src = 32'(a_seconds_s1) + 32'd1;
				min_src = 9'(a_minutes_s1);
				hr_src  = 9'(a_hours_s1);
				day_src = (DAYS_BITS+1)'(a_days_s1);
			end
			FUNC_NORM: begin
				kind_d  = KIND_CARRY;
				sec_src = 32'(a_seconds_s1);
				min_src = 9'(a_minutes_s1);
				hr_src  = 9'(a_hours_s1);
				day_src = (DAYS_BITS+1)'(a_days_s1);
			end
			FUNC_SECS: begin
				kind_d  = KIND_CARRY;
				sec_src = total_seconds_s1;
			end
			default: begin
			end
		endcase
	end

	// Seconds carry into minutes.
	assign sec_q = div60(sec_src);
	assign sec_r = sec_src - sec_q * SEC_PER_MIN;

	always_comb begin
		if (kind_d == KIND_CARRY) begin
			days_d    = day_src;
			hours_d   = hr_src;
			minutes_d = 32'(min_src) + sec_q;
			seconds_d = {2'b00, sec_r[5:0]};
		end else begin
			days_d    = fin_days;
			hours_d   = fin_hours;
			minutes_d = fin_minutes;
			seconds_d = fin_seconds;
		end
	end

	// Second pipeline register.
	always_ff @(posedge clk) begin
		if (ctl.adv_s2) begin
			kind_s2    <= kind_d;
			days_s2    <= days_d;
			hours_s2   <= hours_d;
			minutes_s2 <= minutes_d;
			seconds_s2 <= seconds_d;
			flags_s2   <= flags_d;
		end
	end

endmodule

// ===== rtl/core/dda_carry.sv =====
`timescale 1ns / 1ps
`include "duration_dhms_alu_defines.svh"

module dda_carry import dda_pkg::*; #(
	parameter int DAYS_BITS = DAYS_BITS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pipe_ctl_t            ctl,
	input  kind_t                kind_s2,
	input  logic [DAYS_BITS:0]   days_s2,
	input  logic [8:0]           hours_s2,
	input  logic [31:0]          minutes_s2,
	input  logic [7:0]           seconds_s2,
	input  cmp_flags_t           flags_s2,
	output logic [DAYS_BITS:0]   days_s4,
	output logic [DCARRY_W-1:0]  dcarry_s4,
	output logic [7:0]           hours_s4,
	output logic [7:0]           minutes_s4,
	output logic [7:0]           seconds_s4,
	output cmp_flags_t           flags_s4
);

	kind_t                kind_s3;
	logic [DAYS_BITS:0]   days_s3;
	logic [31:0]          hours_s3;
	logic [7:0]           minutes_s3;
	logic [7:0]           seconds_s3;
	cmp_flags_t           flags_s3;
	kind_t                kind_s4;

	logic [31:0]          min_q;
	logic [31:0]          min_r;
	logic [31:0]          hr_q;
	logic [31:0]          hr_r;

	// Minutes carry into hours.
	assign min_q = div60(minutes_s2);
	assign min_r = minutes_s2 - min_q * SEC_PER_MIN;

	always_ff @(posedge clk) begin
		if (ctl.adv_s3) begin
			kind_s3    <= kind_s2;
			days_s3    <= days_s2;
			seconds_s3 <= seconds_s2;
			flags_s3   <= flags_s2;
			if (kind_s2 == KIND_CARRY) begin
				hours_s3   <= 32'(hours_s2) + min_q;
				minutes_s3 <= {2'b00, min_r[5:0]};
			end else begin
				hours_s3   <= 32'(hours_s2);
				minutes_s3 <= minutes_s2[7:0];
			end
		end
	end

	// Hours carry into days; the days addition follows in the output stage.
	assign hr_q = div24(hours_s3);
	assign hr_r = hours_s3 - hr_q * HOUR_PER_DAY;

	always_ff @(posedge clk) begin
		if (ctl.adv_s4) begin
			kind_s4    <= kind_s3;
			days_s4    <= days_s3;
			minutes_s4 <= minutes_s3;
			seconds_s4 <= seconds_s3;
			flags_s4   <= flags_s3;
			if (kind_s3 == KIND_CARRY) begin
				hours_s4  <= {3'b000, hr_r[4:0]};
				dcarry_s4 <= hr_q[DCARRY_W-1:0];
			end else begin
				hours_s4  <= hours_s3[7:0];
				dcarry_s4 <= '0;
			end
		end
	end

	// A carried item leaves each stage with its lower fields in range.
	`DDA_ASSERT_IMP(a_min_in_range, clk, arst_n, ctl.vld_s3 && (kind_s3 == KIND_CARRY), (minutes_s3 < 8'd60) && (seconds_s3 < 8'd60), "carried minutes or seconds out of range")
	`DDA_ASSERT_IMP(a_hour_in_range, clk, arst_n, ctl.vld_s4 && (kind_s4 == KIND_CARRY), (hours_s4 < 8'd24) && (minutes_s4 < 8'd60), "carried hours or minutes out of range")

endmodule

// ===== rtl/core/dda_out.sv =====
`timescale 1ns / 1ps

module dda_out import dda_pkg::*; #(
	parameter int DAYS_BITS = DAYS_BITS_DEFAULT
) (
	input  logic                 clk,
	input  pipe_ctl_t            ctl,
	input  logic [DAYS_BITS:0]   days_s4,
	input  logic [DCARRY_W-1:0]  dcarry_s4,
	input  logic [7:0]           hours_s4,
	input  logic [7:0]           minutes_s4,
	input  logic [7:0]           seconds_s4,
	input  cmp_flags_t           flags_s4,
	output logic [DAYS_BITS-1:0] out_days,
	output logic [7:0]           out_hours,
	output logic [7:0]           out_minutes,
	output logic [7:0]           out_seconds,
	output logic                 is_less,
	output logic                 is_equal,
	output logic                 is_greater
);

	localparam int DSUM_W = ((DAYS_BITS > DCARRY_W) ? DAYS_BITS : DCARRY_W) + 2;
	localparam logic [DSUM_W-1:0] DAYS_MAX_EXT =
		{{(DSUM_W-DAYS_BITS){1'b0}}, {DAYS_BITS{1'b1}}};

	logic [DSUM_W-1:0]    day_sum;
	logic [DAYS_BITS-1:0] days_sat;
	logic [DAYS_BITS-1:0] out_days_q;
	logic [7:0]           out_hours_q;
	logic [7:0]           out_minutes_q;
	logic [7:0]           out_seconds_q;
	cmp_flags_t           flags_q;

	// Add the carry from hours and saturate the days at their maximum.
	assign day_sum  = DSUM_W'(days_s4) + DSUM_W'(dcarry_s4);
	assign days_sat = (day_sum > DAYS_MAX_EXT) ? {DAYS_BITS{1'b1}} : day_sum[DAYS_BITS-1:0];

	// Output register.
	always_ff @(posedge clk) begin
		if (ctl.adv_o) begin
			out_days_q    <= days_sat;
			out_hours_q   <= hours_s4;
			out_minutes_q <= minutes_s4;
			out_seconds_q <= seconds_s4;
			flags_q       <= flags_s4;
		end
	end

	assign out_days    = out_days_q;
	assign out_hours   = out_hours_q;
	assign out_minutes = out_minutes_q;
	assign out_seconds = out_seconds_q;
	assign is_less     = flags_q.lt;
	assign is_equal    = flags_q.eq;
	assign is_greater  = flags_q.gt;

endmodule

// ===== rtl/core/duration_dhms_alu.sv =====
// Duration arithmetic on days, hours, minutes and seconds.
// The req channel carries an opcode, two operands a and b and a seconds count;
// the rsp channel carries one result per request: the four result fields and
// the three compare flags. Both channels use valid/ready, and a transfer takes
// place at a rising edge with valid and ready both high.
// The transfer edge loads the input register, and the result then moves through
// the seconds carry, minutes carry, hours carry and output registers in turn.
// Throughput: one request per cycle while rsp.ready is high. Each of the three carry
// stages holds one constant reciprocal multiply, which sets the clock period.
// Each stage advances whenever the stage after it is empty or moving, so empty
// slots are squeezed out and req.ready stays high while any slot is free.
// When the receiver holds rsp.ready low, the result stays in the output register
// and the pipeline keeps filling behind it; req.ready drops only once all five
// stages are occupied.
// Reset (arst_n low) empties the pipeline at once; no result is pending after it.
// Days saturate at 2**DAYS_BITS - 1.
`timescale 1ns / 1ps
`include "duration_dhms_alu_defines.svh"

module duration_dhms_alu import dda_pkg::*; #(
	parameter int DAYS_BITS = DAYS_BITS_DEFAULT
) (
	input logic         clk,
	input logic         arst_n,
	dda_req_if.sink     req,
	dda_rsp_if.source   rsp
);

	pipe_ctl_t            ctl;
	logic                 vld_s1;
	logic                 vld_s2;
	logic                 vld_s3;
	logic                 vld_s4;
	logic                 out_vld_q;

	kind_t                kind_s2;
	logic [DAYS_BITS:0]   days_s2;
	logic [8:0]           hours_s2;
	logic [31:0]          minutes_s2;
	logic [7:0]           seconds_s2;
	cmp_flags_t           flags_s2;

	logic [DAYS_BITS:0]   days_s4;
	logic [DCARRY_W-1:0]  dcarry_s4;
	logic [7:0]           hours_s4;
	logic [7:0]           minutes_s4;
	logic [7:0]           seconds_s4;
	cmp_flags_t           flags_s4;

	// Stage advance: a stage loads when it is empty or its successor moves.
	always_comb begin
		ctl.adv_o  = !out_vld_q || rsp.ready;
		ctl.adv_s4 = !vld_s4 || ctl.adv_o;
		ctl.adv_s3 = !vld_s3 || ctl.adv_s4;
		ctl.adv_s2 = !vld_s2 || ctl.adv_s3;
		ctl.adv_s1 = !vld_s1 || ctl.adv_s2;
		ctl.vld_s3 = vld_s3;
		ctl.vld_s4 = vld_s4;
	end

	assign req.ready = ctl.adv_s1;
	assign rsp.valid = out_vld_q;

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (ctl.adv_s1) vld_s1 <= req.valid;
			if (ctl.adv_s2) vld_s2 <= vld_s1;
			if (ctl.adv_s3) vld_s3 <= vld_s2;
			if (ctl.adv_s4) vld_s4 <= vld_s3;
			if (ctl.adv_o)  out_vld_q <= vld_s4;
		end
	end

	// Input register, subtract, compare and seconds carry.
	dda_front #(.DAYS_BITS(DAYS_BITS)) u_front (
		.clk           (clk),
		.ctl           (ctl),
		.func          (req.func),
		.a_days        (req.a_days),
		.a_hours       (req.a_hours),
		.a_minutes     (req.a_minutes),
		.a_seconds     (req.a_seconds),
		.b_days        (req.b_days),
		.b_hours       (req.b_hours),
		.b_minutes     (req.b_minutes),
		.b_seconds     (req.b_seconds),
		.total_seconds (req.total_seconds),
		.kind_s2       (kind_s2),
		.days_s2       (days_s2),
		.hours_s2      (hours_s2),
		.minutes_s2    (minutes_s2),
		.seconds_s2    (seconds_s2),
		.flags_s2      (flags_s2)
	);

	// Minutes and hours carry.
	dda_carry #(.DAYS_BITS(DAYS_BITS)) u_carry (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.kind_s2    (kind_s2),
		.days_s2    (days_s2),
		.hours_s2   (hours_s2),
		.minutes_s2 (minutes_s2),
		.seconds_s2 (seconds_s2),
		.flags_s2   (flags_s2),
		.days_s4    (days_s4),
		.dcarry_s4  (dcarry_s4),
		.hours_s4   (hours_s4),
		.minutes_s4 (minutes_s4),
		.seconds_s4 (seconds_s4),
		.flags_s4   (flags_s4)
	);

	// Days saturation and output register.
	dda_out #(.DAYS_BITS(DAYS_BITS)) u_out (
		.clk         (clk),
		.ctl         (ctl),
		.days_s4     (days_s4),
		.dcarry_s4   (dcarry_s4),
		.hours_s4    (hours_s4),
		.minutes_s4  (minutes_s4),
		.seconds_s4  (seconds_s4),
		.flags_s4    (flags_s4),
		.out_days    (rsp.out_days),
		.out_hours   (rsp.out_hours),
		.out_minutes (rsp.out_minutes),
		.out_seconds (rsp.out_seconds),
		.is_less     (rsp.is_less),
		.is_equal    (rsp.is_equal),
		.is_greater  (rsp.is_greater)
	);

	// At most one compare flag, and a compare result carries all-zero fields.
	`DDA_ASSERT_IMP(a_flags_onehot, clk, arst_n, rsp.valid, $onehot0({rsp.is_less, rsp.is_equal, rsp.is_greater}), "more than one compare flag set")
	`DDA_ASSERT_IMP(a_cmp_fields_zero, clk, arst_n, rsp.valid && (rsp.is_less || rsp.is_equal || rsp.is_greater), (rsp.out_days == '0) && (rsp.out_hours == '0) && (rsp.out_minutes == '0) && (rsp.out_seconds == '0), "compare result with nonzero fields")
	// A request transfer always lands in the input register.
	`DDA_ASSERT_NXT(a_accept_fills_s1, clk, arst_n, req.valid && req.ready, vld_s1, "accepted request lost at the input register")

endmodule
